[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the sign pause controller design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, idle during reset
`define SPL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds whenever ante holds, idle during reset
`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante, idle during reset
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg
// Types and constants of the sign pause and line seek controller.
// ----------------------------------------------------------------------------
package spl_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_TIME   = 2'd0,
		FUNC_LINE   = 2'd1,
		FUNC_DETECT = 2'd2
	} func_t;

	// Configuration register indexes
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 8;
	localparam logic [CfgIdxW-1:0] REG_PAUSE_ENABLE = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_MIN_SCORE = 1'b1;

	// Timing and range limits
	localparam logic [31:0] PAUSE_LEN_MS = 32'd2000;
	localparam logic [31:0] REPAUSE_GAP_MS = 32'd2500;
	localparam logic [31:0] STALE_MS = 32'd350;
	localparam logic [7:0] MAX_SCORE = 8'd100;
	localparam logic [15:0] WIDTH_PX = 16'd320;
	localparam logic [15:0] HEIGHT_PX = 16'd240;
	localparam logic [3:0] MIDDLE_BITS = 4'd6;

	// One input item
	typedef struct packed {
		logic [1:0]         func;
		logic [31:0]        now_ms;
		logic [3:0]         line_mask;
		logic               frame_present;
		logic [31:0]        frame_id;
		logic [31:0]        received_time;
		logic signed [15:0] class_code;
		logic [7:0]         score_value;
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
	} item_t;

	// One result item
	typedef struct packed {
		logic paused;
		logic holding_route;
		logic seeking;
		logic pause_began;
	} result_t;

	// Configuration register contents
	typedef struct packed {
		logic       pause_enable;
		logic [7:0] min_score;
	} cfg_t;

endpackage

[design/spl_in_stage.sv]
// ----------------------------------------------------------------------------
// spl_in_stage
// Input register: captures one item per transfer and holds it until the
// decision stage takes it.
// ----------------------------------------------------------------------------
module spl_in_stage
	import spl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item_in,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic load;

	// Stall only while a held item cannot move on
	assign in_stall = valid_s1 && !advance;
	assign load = in_valid && !in_stall;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload on a transfer
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

[design/spl_core.sv]
// ----------------------------------------------------------------------------
// spl_core
// Controller state and the combinational decision for one item: pause
// expiry, line loss and line restart, detection filtering and pause start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spl_core
	import spl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	input  cfg_t    cfg,
	output result_t result
);

	logic [31:0] last_frame_id_q;
	logic        last_frame_valid_q;
	logic        pause_on_q;
	logic        pause_ever_q;
	logic [31:0] pause_start_time_q;
	logic        line_seek_q;

	logic [31:0] last_frame_id_d;
	logic        last_frame_valid_d;
	logic        pause_on_d;
	logic        pause_ever_d;
	logic [31:0] pause_start_time_d;
	logic        line_seek_d;
	logic        began;

	logic [31:0] since_pause;
	logic [31:0] frame_age;
	logic        detect_ok;
	logic        new_frame;
	logic        repause_ok;
	logic        seek_after_loss;
	logic [1:0]  mode_flags;
	logic        began_paused;

	// Elapsed times, modulo 2^32
	assign since_pause = item_s1.now_ms - pause_start_time_q;
	assign frame_age = item_s1.now_ms - item_s1.received_time;

	// Filter a detection: age, class, score and position
	assign detect_ok = (frame_age <= STALE_MS)
		&& (item_s1.class_code[15:1] == 15'd0)
		&& (item_s1.score_value >= cfg.min_score)
		&& (item_s1.score_value <= MAX_SCORE)
		&& (item_s1.pos_x < WIDTH_PX)
		&& (item_s1.pos_y < HEIGHT_PX);

	assign new_frame = item_s1.frame_present
		&& !(last_frame_valid_q && (item_s1.frame_id == last_frame_id_q));
	assign repause_ok = !pause_ever_q || (since_pause >= REPAUSE_GAP_MS);
	assign seek_after_loss = line_seek_q || (pause_on_q && (item_s1.line_mask == 4'd0));

	// Next state and result for the held item
	always_comb begin
		last_frame_id_d = last_frame_id_q;
		last_frame_valid_d = last_frame_valid_q;
		pause_on_d = pause_on_q;
		pause_ever_d = pause_ever_q;
		pause_start_time_d = pause_start_time_q;
		line_seek_d = line_seek_q;
		began = 1'b0;
		unique case (func_t'(item_s1.func))
			FUNC_TIME: begin
				if (pause_on_q && (since_pause >= PAUSE_LEN_MS)) begin
					pause_on_d = 1'b0;
				end
			end
			FUNC_LINE: begin
				if (pause_on_q && (item_s1.line_mask == 4'd0)) begin
					pause_on_d = 1'b0;
					line_seek_d = 1'b1;
				end
				if (seek_after_loss && ((item_s1.line_mask & MIDDLE_BITS) != 4'd0)) begin
					line_seek_d = 1'b0;
					pause_on_d = 1'b1;
					pause_start_time_d = item_s1.now_ms;
					began = 1'b1;
				end
			end
			FUNC_DETECT: begin
				if (new_frame) begin
					last_frame_id_d = item_s1.frame_id;
					last_frame_valid_d = 1'b1;
					if (detect_ok && !line_seek_q && cfg.pause_enable && repause_ok) begin
						pause_ever_d = 1'b1;
						pause_on_d = 1'b1;
						pause_start_time_d = item_s1.now_ms;
						began = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		result.paused = pause_on_d;
		result.holding_route = pause_on_d || line_seek_d;
		result.seeking = line_seek_d;
		result.pause_began = began;
	end

	// Commit state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_frame_id_q <= '0;
			last_frame_valid_q <= 1'b0;
			pause_on_q <= 1'b0;
			pause_ever_q <= 1'b0;
			pause_start_time_q <= '0;
			line_seek_q <= 1'b0;
		end else if (advance) begin
			last_frame_id_q <= last_frame_id_d;
			last_frame_valid_q <= last_frame_valid_d;
			pause_on_q <= pause_on_d;
			pause_ever_q <= pause_ever_d;
			pause_start_time_q <= pause_start_time_d;
			line_seek_q <= line_seek_d;
		end
	end

	// Gather the mode flags and the pause start condition for the checks
	assign mode_flags = {pause_on_q, line_seek_q};
	assign began_paused = !result.pause_began || (pause_on_d && !line_seek_d);

	`SPL_ASSERT(a_pause_seek_excl, clk, arst_n, mode_flags != 2'b11, "paused while seeking")
	`SPL_ASSERT_NEXT(a_ever_sticky, clk, arst_n, pause_ever_q, pause_ever_q, "pause_ever cleared")
	`SPL_ASSERT_NEXT(a_hold_state, clk, arst_n, !advance, $stable(mode_flags), "state moved")
	`SPL_ASSERT_IMPL(a_began_paused, clk, arst_n, advance, began_paused, "began but not paused")

endmodule

[design/sign_pause_line_seek_controller_unit.sv]
// ----------------------------------------------------------------------------
// sign_pause_line_seek_controller_unit
// Top level of the sign pause and line seek controller.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output does not stall and returns one
// result per item. An item transfers into the input register, is decided
// there against the controller state, and its result lands in the output
// register. The rate is set by the state update loop in spl_core. While a
// finished result waits on a stalled output, the input register takes one
// more item and then stalls the input. Configuration is a write port:
// index 0 is pause_enable (data bit 0), index 1 is min_score (data bits 7:0),
// to be written only while the block is idle; the block does not enforce it.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sign_pause_line_seek_controller_unit
	import spl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [31:0]         now_ms,
	input  logic [3:0]          line_mask,
	input  logic                frame_present,
	input  logic [31:0]         frame_id,
	input  logic [31:0]         received_time,
	input  logic signed [15:0]  class_code,
	input  logic [7:0]          score_value,
	input  logic [15:0]         pos_x,
	input  logic [15:0]         pos_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                paused,
	output logic                holding_route,
	output logic                seeking,
	output logic                pause_began
);

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    holding_ok;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAUSE_ENABLE: cfg_q.pause_enable <= cfg_data[0];
				REG_MIN_SCORE:    cfg_q.min_score <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Pack the payload ports
	assign item_in = '{
		func: func,
		now_ms: now_ms,
		line_mask: line_mask,
		frame_present: frame_present,
		frame_id: frame_id,
		received_time: received_time,
		class_code: class_code,
		score_value: score_value,
		pos_x: pos_x,
		pos_y: pos_y
	};

	// Move the held item on when the result register is free or draining
	assign advance = valid_s1 && (!out_valid_q || !out_stall);

	spl_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	spl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result register: load on advance, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign paused = result_q.paused;
	assign holding_route = result_q.holding_route;
	assign seeking = result_q.seeking;
	assign pause_began = result_q.pause_began;

	// Holding flag must follow the paused and seeking flags
	assign holding_ok = result_q.holding_route == (result_q.paused || result_q.seeking);

	`SPL_ASSERT_NEXT(a_advance_fills, clk, arst_n, advance, out_valid_q, "result lost")
	`SPL_ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_valid_q && out_stall, !advance, "overwritten")
	`SPL_ASSERT_IMPL(a_holding_flag, clk, arst_n, out_valid_q, holding_ok, "holding flag mismatch")

endmodule
